/* hw/rtl/rie_pkg.sv */
// Package for the integer instruction executor: codes, opcodes, state and
// result structs. No dependencies.
`default_nettype none
package rie_pkg;

  localparam int unsigned XLEN          = 32;
  localparam int unsigned RegCountDflt  = 32;
  localparam logic [31:0] StartPcReset  = 32'h8000_0000;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_FETCH = 2'd1,
    ACT_MEM   = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    KIND_FETCH  = 3'd0,
    KIND_LOAD   = 3'd1,
    KIND_STORE  = 3'd2,
    KIND_HALT   = 3'd3,
    KIND_IGNORE = 3'd4
  } kind_e;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  // pending access codes
  localparam logic [2:0] ACC_LB  = 3'd0;
  localparam logic [2:0] ACC_LH  = 3'd1;
  localparam logic [2:0] ACC_LW  = 3'd2;
  localparam logic [2:0] ACC_LBU = 3'd3;
  localparam logic [2:0] ACC_LHU = 3'd4;
  localparam logic [2:0] ACC_SB  = 3'd5;

  localparam logic [6:0] OP_LUI   = 7'd1;
  localparam logic [6:0] OP_AUIPC = 7'd2;
  localparam logic [6:0] OP_JAL   = 7'd3;
  localparam logic [6:0] OP_JALR  = 7'd4;
  localparam logic [6:0] OP_BEQ   = 7'd5;
  localparam logic [6:0] OP_BNE   = 7'd6;
  localparam logic [6:0] OP_BLT   = 7'd7;
  localparam logic [6:0] OP_BGE   = 7'd8;
  localparam logic [6:0] OP_BLTU  = 7'd9;
  localparam logic [6:0] OP_BGEU  = 7'd10;
  localparam logic [6:0] OP_LB    = 7'd11;
  localparam logic [6:0] OP_LH    = 7'd12;
  localparam logic [6:0] OP_LW    = 7'd13;
  localparam logic [6:0] OP_LBU   = 7'd14;
  localparam logic [6:0] OP_LHU   = 7'd15;
  localparam logic [6:0] OP_SB    = 7'd16;
  localparam logic [6:0] OP_SH    = 7'd17;
  localparam logic [6:0] OP_SW    = 7'd18;
  localparam logic [6:0] OP_ADDI  = 7'd19;
  localparam logic [6:0] OP_SLTI  = 7'd20;
  localparam logic [6:0] OP_SLTIU = 7'd21;
  localparam logic [6:0] OP_XORI  = 7'd22;
  localparam logic [6:0] OP_ORI   = 7'd23;
  localparam logic [6:0] OP_ANDI  = 7'd24;
  localparam logic [6:0] OP_SLLI  = 7'd25;
  localparam logic [6:0] OP_SRLI  = 7'd26;
  localparam logic [6:0] OP_SRAI  = 7'd27;
  localparam logic [6:0] OP_ADD   = 7'd28;
  localparam logic [6:0] OP_SUB   = 7'd29;
  localparam logic [6:0] OP_SLL   = 7'd30;
  localparam logic [6:0] OP_SRL   = 7'd31;
  localparam logic [6:0] OP_SRA   = 7'd32;
  localparam logic [6:0] OP_SLT   = 7'd33;
  localparam logic [6:0] OP_SLTU  = 7'd34;

  typedef struct packed {
    logic [31:0] pc;
    logic [31:0] fpc;
    logic        halted;
    logic        awaiting;
    logic [2:0]  pacc;
    logic [4:0]  pdest;
  } core_state_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] address;
    logic [1:0]  access_size;
    logic [31:0] store_data;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
  } result_t;

endpackage
`default_nettype wire

/* hw/rtl/rie_in_if.sv */
// Input channel of the executor: valid/ready plus the input item fields.
// No dependencies.
`default_nettype none
interface rie_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] word;
  logic        fault;
  modport source (output valid, output action, output word, output fault, input ready);
  modport sink (input valid, input action, input word, input fault, output ready);
endinterface
`default_nettype wire

/* hw/rtl/rie_out_if.sv */
// Result channel of the executor: valid/ready plus the result fields.
// No dependencies.
`default_nettype none
interface rie_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] address;
  logic [1:0]  access_size;
  logic [31:0] store_data;
  logic        reg_write;
  logic [4:0]  reg_index;
  logic [31:0] reg_value;
  modport source (output valid, output kind, output address, output access_size,
                  output store_data, output reg_write, output reg_index,
                  output reg_value, input ready);
  modport sink (input valid, input kind, input address, input access_size,
                input store_data, input reg_write, input reg_index,
                input reg_value, output ready);
endinterface
`default_nettype wire

/* hw/rtl/risc_integer_instruction_executor.sv */
// Top level of the integer instruction executor: register file RAMs,
// operand stage, execute unit, output register. Depends on rie_pkg,
// rie_in_if, rie_out_if, rie_ram and rie_exec.
//
// The core takes one input beat per cycle and answers each with exactly one
// result beat. The register-file read for an accepted beat starts at the
// accepting edge (two synchronous RAM copies, one read port each, registered
// read data). The beat then executes from the operand stage into the output
// register once that register is free. The sustained rate is one beat per
// cycle whenever the result side keeps ready high. A register written by one
// instruction and read by the very next is forwarded from a bypass register,
// so back-to-back dependent instructions cost nothing extra. Register-file
// reset is held in one valid flop per entry, cleared by reset, so no clearing
// pass follows reset: the core accepts beats as soon as reset is released.
// The user must write start_pc through cfg_we_i/cfg_wdata_i only while the
// core is idle; the block itself does not enforce this.
`default_nettype none
module risc_integer_instruction_executor #(
  parameter int unsigned REG_COUNT = rie_pkg::RegCountDflt
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  rie_in_if.sink           in_i,
  rie_out_if.source        out_o
);
  localparam int unsigned AW = $clog2(REG_COUNT);

  logic [31:0] start_pc_q;
  logic        s1_v_q, out_v_q, s1_adv, accept;
  logic [1:0]  s1_action_q;
  logic [31:0] s1_word_q;
  logic        s1_fault_q;
  logic [4:0]  s1_idx2_q;
  logic [4:0]  rd_idx1, rd_idx2;
  logic        sel_rd;
  logic [31:0] rdata1, rdata2, opa, opb;
  logic [REG_COUNT-1:0] valid_q;
  logic        wr_v_q;
  logic [4:0]  wr_idx_q;
  logic [31:0] wr_val_q;
  rie_pkg::core_state_t st_q, st_d;
  rie_pkg::result_t     res, out_q;
  logic        we;

  // Handshake: hold s1 while the output register is full and not taken.
  assign s1_adv     = s1_v_q && (!out_v_q || out_o.ready);
  assign in_i.ready = !s1_v_q || s1_adv;
  assign accept     = in_i.valid && in_i.ready;

  // Branches and stores read their second source from the rd field.
  assign sel_rd  = (in_i.word[6:0] >= rie_pkg::OP_BEQ && in_i.word[6:0] <= rie_pkg::OP_BGEU) ||
                   (in_i.word[6:0] >= rie_pkg::OP_SB && in_i.word[6:0] <= rie_pkg::OP_SW);
  assign rd_idx1 = in_i.word[16:12];
  assign rd_idx2 = sel_rd ? in_i.word[11:7] : in_i.word[21:17];

  assign we = s1_adv && res.reg_write;

  rie_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (res.reg_index[AW-1:0]),
    .wdata_i (res.reg_value),
    .re_i    (accept),
    .raddr_i (rd_idx1[AW-1:0]),
    .rdata_o (rdata1)
  );

  rie_ram #(.WIDTH(32), .DEPTH(REG_COUNT)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (res.reg_index[AW-1:0]),
    .wdata_i (res.reg_value),
    .re_i    (accept),
    .raddr_i (rd_idx2[AW-1:0]),
    .rdata_o (rdata2)
  );

  // Resolve an operand: x0 and out-of-range read zero, then bypass, then
  // never-written entries read zero.
  function automatic logic [31:0] resolve(input logic [4:0] idx, input logic [31:0] rdata,
                                          input logic [REG_COUNT-1:0] vld,
                                          input logic fv, input logic [4:0] fidx,
                                          input logic [31:0] fval);
    logic [31:0] r;
    if (idx == 5'd0 || 32'(idx) >= REG_COUNT) begin
      r = '0;
    end else if (fv && fidx == idx) begin
      r = fval;
    end else if (vld[idx[AW-1:0]]) begin
      r = rdata;
    end else begin
      r = '0;
    end
    return r;
  endfunction

  assign opa = resolve(s1_word_q[16:12], rdata1, valid_q, wr_v_q, wr_idx_q, wr_val_q);
  assign opb = resolve(s1_idx2_q, rdata2, valid_q, wr_v_q, wr_idx_q, wr_val_q);

  rie_exec #(.REG_COUNT(REG_COUNT)) u_exec (
    .action_i   (s1_action_q),
    .word_i     (s1_word_q),
    .fault_i    (s1_fault_q),
    .opa_i      (opa),
    .opb_i      (opb),
    .start_pc_i (start_pc_q),
    .st_i       (st_q),
    .st_o       (st_d),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_pc_q       <= rie_pkg::StartPcReset;
      s1_v_q           <= 1'b0;
      out_v_q          <= 1'b0;
      valid_q          <= '0;
      wr_v_q           <= 1'b0;
      st_q             <= '{pc: '0, fpc: '0, halted: 1'b1, awaiting: 1'b0,
                            pacc: '0, pdest: '0};
    end else begin
      if (cfg_we_i) begin
        start_pc_q <= cfg_wdata_i;
      end
      if (accept) begin
        s1_v_q <= 1'b1;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_adv) begin
        out_v_q <= 1'b1;
        st_q    <= st_d;
        wr_v_q  <= res.reg_write;
        if (res.reg_write) begin
          valid_q[res.reg_index[AW-1:0]] <= 1'b1;
        end
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Payload registers: advance with their stage.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_action_q <= in_i.action;
      s1_word_q   <= in_i.word;
      s1_fault_q  <= in_i.fault;
      s1_idx2_q   <= rd_idx2;
    end
    if (s1_adv) begin
      out_q    <= res;
      wr_idx_q <= res.reg_index;
      wr_val_q <= res.reg_value;
    end
  end

  assign out_o.valid       = out_v_q;
  assign out_o.kind        = out_q.kind;
  assign out_o.address     = out_q.address;
  assign out_o.access_size = out_q.access_size;
  assign out_o.store_data  = out_q.store_data;
  assign out_o.reg_write   = out_q.reg_write;
  assign out_o.reg_index   = out_q.reg_index;
  assign out_o.reg_value   = out_q.reg_value;

`ifndef SYNTH
  a_s1_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_v_q)
    else $error("accepted beat did not reach operand stage");
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !s1_adv) |=> (s1_v_q && $stable(s1_word_q)))
    else $error("stalled operand stage lost its beat");
  a_bypass_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_v_q |-> (wr_idx_q != 5'd0))
    else $error("bypass holds a write to x0");
  a_halt_ignore: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && st_q.halted && s1_action_q == rie_pkg::ACT_FETCH)
      |=> (out_q.kind == rie_pkg::KIND_IGNORE))
    else $error("fetch while halted was not ignored");
`endif
endmodule
`default_nettype wire

/* hw/rtl/rie_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module rie_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/rie_exec.sv */
// Execute unit: one item against resolved operands and the core state.
// Depends on rie_pkg.
`default_nettype none
module rie_exec #(
  parameter int unsigned REG_COUNT = rie_pkg::RegCountDflt
) (
  input  wire logic [1:0]          action_i,
  input  wire logic [31:0]         word_i,
  input  wire logic                fault_i,
  input  wire logic [31:0]         opa_i,
  input  wire logic [31:0]         opb_i,
  input  wire logic [31:0]         start_pc_i,
  input  wire rie_pkg::core_state_t st_i,
  output rie_pkg::core_state_t     st_o,
  output rie_pkg::result_t         res_o
);
  logic [6:0]  op;
  logic [4:0]  rd;
  logic [31:0] imm, jof, bof, upper, nfpc, v;
  logic        do_adv, do_wr, do_halt, take, is_byte;
  logic [4:0]  dest;

  assign op    = word_i[6:0];
  assign rd    = word_i[11:7];
  assign imm   = {{20{word_i[31]}}, word_i[31:20]};
  assign jof   = {{11{word_i[31]}}, word_i[31:12], 1'b0};
  assign bof   = {{19{word_i[31]}}, word_i[31:20], 1'b0};
  assign upper = {word_i[31:12], 12'd0};

  always_comb begin
    st_o    = st_i;
    res_o   = '0;
    do_adv  = 1'b0;
    do_wr   = 1'b0;
    do_halt = 1'b0;
    take    = 1'b0;
    dest    = rd;
    v       = '0;
    nfpc    = st_i.fpc;
    is_byte = (st_i.pacc == rie_pkg::ACC_LB) || (st_i.pacc == rie_pkg::ACC_LBU) ||
              (st_i.pacc == rie_pkg::ACC_SB);
    if (action_i == rie_pkg::ACT_START) begin
      st_o.pc       = start_pc_i;
      st_o.fpc      = '0;
      st_o.halted   = 1'b0;
      st_o.awaiting = 1'b0;
      st_o.pacc     = '0;
      st_o.pdest    = '0;
      res_o.kind        = rie_pkg::KIND_FETCH;
      res_o.address     = start_pc_i;
      res_o.access_size = rie_pkg::SIZE_WORD;
    end else if (action_i == rie_pkg::ACT_NONE || st_i.halted) begin
      res_o.kind = rie_pkg::KIND_IGNORE;
    end else if (action_i == rie_pkg::ACT_FETCH) begin
      if (st_i.awaiting) begin
        res_o.kind = rie_pkg::KIND_IGNORE;
      end else if (fault_i) begin
        do_halt = 1'b1;
      end else begin
        nfpc   = st_i.pc + 32'd4;
        do_adv = 1'b1;
        do_wr  = 1'b1;
        unique case (op)
          rie_pkg::OP_LUI:   v = upper;
          rie_pkg::OP_AUIPC: v = st_i.pc + upper;
          rie_pkg::OP_JAL: begin
            nfpc = st_i.pc + jof;
            v    = st_i.pc + 32'd4;
          end
          rie_pkg::OP_JALR: begin
            nfpc = (opa_i + imm) & 32'hFFFF_FFFE;
            v    = st_i.pc + 32'd4;
          end
          rie_pkg::OP_BEQ, rie_pkg::OP_BNE, rie_pkg::OP_BLT,
          rie_pkg::OP_BGE, rie_pkg::OP_BLTU, rie_pkg::OP_BGEU: begin
            do_wr = 1'b0;
            case (op)
              rie_pkg::OP_BEQ:  take = (opa_i == opb_i);
              rie_pkg::OP_BNE:  take = (opa_i != opb_i);
              rie_pkg::OP_BLT:  take = ($signed(opa_i) < $signed(opb_i));
              rie_pkg::OP_BGE:  take = ($signed(opa_i) >= $signed(opb_i));
              rie_pkg::OP_BLTU: take = (opa_i < opb_i);
              default:          take = (opa_i >= opb_i);
            endcase
            if (take) begin
              nfpc = st_i.pc + bof;
            end
          end
          rie_pkg::OP_LB, rie_pkg::OP_LH, rie_pkg::OP_LW,
          rie_pkg::OP_LBU, rie_pkg::OP_LHU: begin
            do_adv        = 1'b0;
            st_o.fpc      = nfpc;
            st_o.pacc     = 3'(op - rie_pkg::OP_LB);
            st_o.pdest    = rd;
            st_o.awaiting = 1'b1;
            res_o.kind    = rie_pkg::KIND_LOAD;
            res_o.address = opa_i + imm;
            if (op == rie_pkg::OP_LW) begin
              res_o.access_size = rie_pkg::SIZE_WORD;
            end else if (op == rie_pkg::OP_LH || op == rie_pkg::OP_LHU) begin
              res_o.access_size = rie_pkg::SIZE_HALF;
            end else begin
              res_o.access_size = rie_pkg::SIZE_BYTE;
            end
          end
          rie_pkg::OP_SB, rie_pkg::OP_SH, rie_pkg::OP_SW: begin
            do_adv            = 1'b0;
            st_o.fpc          = nfpc;
            st_o.pacc         = 3'(op - rie_pkg::OP_LB);
            st_o.pdest        = '0;
            st_o.awaiting     = 1'b1;
            res_o.kind        = rie_pkg::KIND_STORE;
            res_o.address     = opa_i + imm;
            res_o.access_size = 2'(op - rie_pkg::OP_SB);
            res_o.store_data  = opb_i;
          end
          rie_pkg::OP_ADDI:  v = opa_i + imm;
          rie_pkg::OP_SLTI:  v = {31'd0, $signed(opa_i) < $signed(imm)};
          rie_pkg::OP_SLTIU: v = {31'd0, opa_i < imm};
          rie_pkg::OP_XORI:  v = opa_i ^ imm;
          rie_pkg::OP_ORI:   v = opa_i | imm;
          rie_pkg::OP_ANDI:  v = opa_i & imm;
          rie_pkg::OP_SLLI:  v = opa_i << word_i[24:20];
          rie_pkg::OP_SRLI:  v = opa_i >> word_i[24:20];
          rie_pkg::OP_SRAI:  v = 32'($signed(opa_i) >>> word_i[24:20]);
          rie_pkg::OP_ADD:   v = opa_i + opb_i;
          rie_pkg::OP_SUB:   v = opa_i - opb_i;
          rie_pkg::OP_SLL:   v = opa_i << opb_i[4:0];
          rie_pkg::OP_SRL:   v = opa_i >> opb_i[4:0];
          rie_pkg::OP_SRA:   v = 32'($signed(opa_i) >>> opb_i[4:0]);
          rie_pkg::OP_SLT:   v = {31'd0, $signed(opa_i) < $signed(opb_i)};
          rie_pkg::OP_SLTU:  v = {31'd0, opa_i < opb_i};
          default: begin
            do_adv   = 1'b0;
            do_halt  = 1'b1;
            st_o.fpc = nfpc;
          end
        endcase
      end
    end else begin
      // memory response
      if (!st_i.awaiting) begin
        res_o.kind = rie_pkg::KIND_IGNORE;
      end else if (fault_i && !is_byte) begin
        do_halt = 1'b1;
      end else begin
        st_o.awaiting = 1'b0;
        do_adv = 1'b1;
        do_wr  = 1'b1;
        dest   = st_i.pdest;
        case (st_i.pacc)
          rie_pkg::ACC_LB:  v = {{24{word_i[7]}}, word_i[7:0]};
          rie_pkg::ACC_LH:  v = {{16{word_i[15]}}, word_i[15:0]};
          rie_pkg::ACC_LW:  v = word_i;
          rie_pkg::ACC_LBU: v = {24'd0, word_i[7:0]};
          rie_pkg::ACC_LHU: v = {16'd0, word_i[15:0]};
          default:          do_wr = 1'b0;
        endcase
      end
    end

    if (do_halt) begin
      st_o.halted   = 1'b1;
      st_o.awaiting = 1'b0;
      res_o.kind    = rie_pkg::KIND_HALT;
      res_o.address = st_i.pc;
    end
    if (do_adv) begin
      if (do_wr && dest != 5'd0 && 32'(dest) < REG_COUNT) begin
        res_o.reg_write = 1'b1;
        res_o.reg_index = dest;
        res_o.reg_value = v;
      end
      st_o.fpc          = nfpc;
      st_o.pc           = nfpc;
      res_o.kind        = rie_pkg::KIND_FETCH;
      res_o.address     = nfpc;
      res_o.access_size = rie_pkg::SIZE_WORD;
    end
  end
endmodule
`default_nettype wire

/* tb/rie_scoreboard.sv */
// Checker for the integer instruction executor: mirrors the core state, predicts one
// result per accepted input beat and compares result beats field by field.
// Depends on rie_pkg, rie_in_if and rie_out_if.
`timescale 1ns / 1ps
module rie_scoreboard
  import rie_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  rie_in_if    in_m,
  rie_out_if   out_m,
  output int   err_cnt_o,
  output int   pending_o,
  output int   checked_o,
  output logic halted_o,
  output logic waiting_o
);

  logic [31:0] start_pc;
  logic [31:0] regs [32];
  logic [31:0] pc, fpc;
  logic        halted, waiting;
  logic [2:0]  pacc;
  logic [4:0]  pdest;
  result_t     nxt;
  result_t     expected_q [$];

  assign pending_o = expected_q.size();
  assign halted_o  = halted;
  assign waiting_o = waiting;

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t: result %0d field %s got %h want %h", $time, checked_o, field, got, want);
    err_cnt_o++;
  endtask

  function automatic void halt_core();
    halted  = 1'b1;
    waiting = 1'b0;
    nxt.kind    = KIND_HALT;
    nxt.address = pc;
  endfunction

  // Retire: write back (x0 dropped), move on to the next PC, ask for a fetch.
  function automatic void retire(logic [4:0] dest, logic [31:0] val, logic wr);
    if (wr && dest != 5'd0) begin
      regs[dest]    = val;
      nxt.reg_write = 1'b1;
      nxt.reg_index = dest;
      nxt.reg_value = val;
    end
    pc = fpc;
    nxt.kind        = KIND_FETCH;
    nxt.address     = pc;
    nxt.access_size = SIZE_WORD;
  endfunction

  function automatic void execute_word(logic [31:0] w);
    logic [6:0]  op;
    logic [4:0]  rd;
    logic [31:0] a, b, c, imm, boff, v;
    logic [4:0]  sh;
    logic        take;
    op   = w[6:0];
    rd   = w[11:7];
    a    = regs[w[16:12]];
    b    = regs[rd];
    c    = regs[w[21:17]];
    imm  = {{20{w[31]}}, w[31:20]};
    sh   = w[24:20];
    boff = {{19{w[31]}}, w[31:20], 1'b0};
    take = 1'b0;
    v    = '0;
    fpc  = pc + 32'd4;
    case (op)
      OP_LUI:   v = {w[31:12], 12'd0};
      OP_AUIPC: v = pc + {w[31:12], 12'd0};
      OP_JAL: begin
        fpc = pc + {{11{w[31]}}, w[31:12], 1'b0};
        v   = pc + 32'd4;
      end
      OP_JALR: begin
        fpc = (a + imm) & 32'hFFFF_FFFE;
        v   = pc + 32'd4;
      end
      OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU: begin
        case (op)
          OP_BEQ:  take = (a == b);
          OP_BNE:  take = (a != b);
          OP_BLT:  take = ($signed(a) < $signed(b));
          OP_BGE:  take = ($signed(a) >= $signed(b));
          OP_BLTU: take = (a < b);
          default: take = (a >= b);
        endcase
        if (take) fpc = pc + boff;
        retire(5'd0, '0, 1'b0);
        return;
      end
      OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: begin
        pacc    = 3'(op - OP_LB);
        pdest   = rd;
        waiting = 1'b1;
        nxt.kind    = KIND_LOAD;
        nxt.address = a + imm;
        nxt.access_size = (op == OP_LW) ? SIZE_WORD :
                          (op == OP_LH || op == OP_LHU) ? SIZE_HALF : SIZE_BYTE;
        return;
      end
      OP_SB, OP_SH, OP_SW: begin
        pacc    = 3'(op - OP_LB);
        pdest   = 5'd0;
        waiting = 1'b1;
        nxt.kind        = KIND_STORE;
        nxt.address     = a + imm;
        nxt.access_size = 2'(op - OP_SB);
        nxt.store_data  = b;
        return;
      end
      OP_ADDI:  v = a + imm;
      OP_SLTI:  v = {31'd0, $signed(a) < $signed(imm)};
      OP_SLTIU: v = {31'd0, a < imm};
      OP_XORI:  v = a ^ imm;
      OP_ORI:   v = a | imm;
      OP_ANDI:  v = a & imm;
      OP_SLLI:  v = a << sh;
      OP_SRLI:  v = a >> sh;
      OP_SRAI:  v = $signed(a) >>> sh;
      OP_ADD:   v = a + c;
      OP_SUB:   v = a - c;
      OP_SLL:   v = a << c[4:0];
      OP_SRL:   v = a >> c[4:0];
      OP_SRA:   v = $signed(a) >>> c[4:0];
      OP_SLT:   v = {31'd0, $signed(a) < $signed(c)};
      OP_SLTU:  v = {31'd0, a < c};
      default: begin
        halt_core();
        return;
      end
    endcase
    retire(rd, v, 1'b1);
  endfunction

  // Memory response: byte accesses ignore the fault, half and word halt on it.
  function automatic void finish_access(logic [31:0] w, logic fault);
    logic [31:0] v;
    if (fault && !(pacc == ACC_LB || pacc == ACC_LBU || pacc == ACC_SB)) begin
      halt_core();
      return;
    end
    waiting = 1'b0;
    case (pacc)
      ACC_LB:  v = {{24{w[7]}}, w[7:0]};
      ACC_LH:  v = {{16{w[15]}}, w[15:0]};
      ACC_LW:  v = w;
      ACC_LBU: v = {24'd0, w[7:0]};
      ACC_LHU: v = {16'd0, w[15:0]};
      default: begin
        retire(5'd0, '0, 1'b0);
        return;
      end
    endcase
    retire(pdest, v, 1'b1);
  endfunction

  function automatic result_t predict_beat(logic [1:0] act, logic [31:0] w, logic fault);
    nxt = '0;
    if (act == ACT_START) begin
      pc      = start_pc;
      fpc     = '0;
      halted  = 1'b0;
      waiting = 1'b0;
      pacc    = '0;
      pdest   = '0;
      nxt.kind        = KIND_FETCH;
      nxt.address     = pc;
      nxt.access_size = SIZE_WORD;
    end else if (act == ACT_NONE || halted) begin
      nxt.kind = KIND_IGNORE;
    end else if (act == ACT_FETCH) begin
      if (waiting) nxt.kind = KIND_IGNORE;
      else if (fault) halt_core();
      else execute_word(w);
    end else begin
      if (!waiting) nxt.kind = KIND_IGNORE;
      else finish_access(w, fault);
    end
    return nxt;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got, want;
    if (!rst_ni) begin
      start_pc = StartPcReset;
      foreach (regs[i]) regs[i] = '0;
      pc = '0; fpc = '0; halted = 1'b1; waiting = 1'b0; pacc = '0; pdest = '0;
      expected_q.delete();
      err_cnt_o = 0;
      checked_o = 0;
    end else begin
      if (cfg_we_i) start_pc = cfg_wdata_i;
      // Predict first: a beat's own result can never leave in the same cycle.
      if (in_m.valid && in_m.ready)
        expected_q.push_back(predict_beat(in_m.action, in_m.word, in_m.fault));
      if (out_m.valid && out_m.ready) begin
        got = '{out_m.kind, out_m.address, out_m.access_size, out_m.store_data,
                out_m.reg_write, out_m.reg_index, out_m.reg_value};
        if (expected_q.size() == 0) begin
          report("unexpected", {29'd0, got.kind}, '0);
        end else begin
          want = expected_q.pop_front();
          if (got.kind !== want.kind) report("kind", got.kind, want.kind);
          if (got.address !== want.address) report("address", got.address, want.address);
          if (got.access_size !== want.access_size)
            report("access_size", got.access_size, want.access_size);
          if (got.store_data !== want.store_data)
            report("store_data", got.store_data, want.store_data);
          if (got.reg_write !== want.reg_write)
            report("reg_write", got.reg_write, want.reg_write);
          if (got.reg_index !== want.reg_index)
            report("reg_index", got.reg_index, want.reg_index);
          if (got.reg_value !== want.reg_value)
            report("reg_value", got.reg_value, want.reg_value);
        end
        checked_o++;
      end
    end
  end

endmodule

/* tb/risc_integer_instruction_executor_tb.sv */
// Top of the executor testbench: clock, reset, directed and random stimulus,
// result-side stalls and the verdict. Depends on rie_pkg, the channel
// interfaces, the executor and rie_scoreboard.
`timescale 1ns / 1ps
module risc_integer_instruction_executor_tb;
  import rie_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int PhaseItems = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  int          err_cnt, pending, checked;
  logic        core_halted, core_waiting;
  logic        no_idle;
  int          cycles;
  int          beats_sent;

  rie_in_if  in_if ();
  rie_out_if out_if ();

  risc_integer_instruction_executor DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  rie_scoreboard u_scoreboard (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_m        (in_if),
    .out_m       (out_if),
    .err_cnt_o   (err_cnt),
    .pending_o   (pending),
    .checked_o   (checked),
    .halted_o    (core_halted),
    .waiting_o   (core_waiting)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop: a hung handshake or a lost result ends here.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: stall at random before each beat, none in quiet phases.
  initial begin
    int stall;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = no_idle ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready = 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  // Drive one beat: idle for a random gap, then hold valid until accepted.
  task automatic send_beat(logic [1:0] act, logic [31:0] w, logic fault);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    repeat (gap) @(negedge clk_i);
    in_if.valid  = 1'b1;
    in_if.action = act;
    in_if.word   = w;
    in_if.fault  = fault;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
    in_if.valid = 1'b0;
    beats_sent++;
  endtask

  // Wait until every result is back, let the pipeline drain, then load start_pc.
  task automatic write_start_pc(logic [31:0] val);
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_wdata = val;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  function automatic logic [31:0] insn(logic [6:0] op, logic [4:0] rd, logic [4:0] rs1,
                                       logic [11:0] imm);
    return {imm, 3'd0, rs1, rd, op};
  endfunction

  // Mostly well-formed traffic that follows the core's state, some noise.
  task automatic random_phase(int n, bit hold_midway);
    logic [31:0] w;
    for (int i = 0; i < n; i++) begin
      if (hold_midway && i == n / 2) while (pending != 0) @(negedge clk_i);
      w = $urandom;
      if ($urandom_range(0, 99) < 8) begin
        send_beat(2'($urandom_range(0, 3)), w, 1'($urandom_range(0, 1)));
      end else if (core_halted) begin
        send_beat(ACT_START, w, 1'($urandom_range(0, 1)));
      end else if (core_waiting) begin
        send_beat(ACT_MEM, w, $urandom_range(0, 9) == 0);
      end else begin
        if ($urandom_range(0, 99) < 95) w[6:0] = 7'($urandom_range(1, 34));
        send_beat(ACT_FETCH, w, $urandom_range(0, 39) == 0);
      end
    end
  endtask

  initial begin
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_if.valid  = 1'b0;
    in_if.action = ACT_NONE;
    in_if.word   = '0;
    in_if.fault  = 1'b0;
    no_idle      = 1'b0;
    cycles       = 0;
    beats_sent   = 0;
    rst_ni       = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: first start uses the reset value of start_pc.
    send_beat(ACT_START, '0, 1'b0);
    send_beat(ACT_FETCH, insn(OP_LUI, 5'd1, 5'd31, 12'hFFF), 1'b0);
    send_beat(ACT_FETCH, insn(OP_ADDI, 5'd2, 5'd1, 12'h7FF), 1'b0);
    send_beat(ACT_FETCH, insn(OP_ADDI, 5'd3, 5'd0, 12'hFFF), 1'b0);
    send_beat(ACT_FETCH, insn(OP_SRAI, 5'd4, 5'd1, 12'd31), 1'b0);
    send_beat(ACT_FETCH, insn(OP_JAL, 5'd9, 5'd31, 12'h800), 1'b0);
    send_beat(ACT_FETCH, insn(OP_BGEU, 5'd0, 5'd3, 12'h801), 1'b0);
    // Byte load with a fault: the fault is dropped and the byte sign-extends.
    send_beat(ACT_FETCH, insn(OP_LB, 5'd5, 5'd0, 12'd0), 1'b0);
    send_beat(ACT_MEM, 32'h0000_0080, 1'b1);
    send_beat(ACT_FETCH, insn(OP_LH, 5'd6, 5'd2, 12'h001), 1'b0);
    send_beat(ACT_MEM, 32'hFFFF_8000, 1'b0);
    send_beat(ACT_FETCH, insn(OP_SB, 5'd3, 5'd1, 12'hFFF), 1'b0);
    send_beat(ACT_MEM, 32'hFFFF_FFFF, 1'b1);
    // Word store with a fault halts; then the ignored cases while halted.
    send_beat(ACT_FETCH, insn(OP_SW, 5'd4, 5'd1, 12'd4), 1'b0);
    send_beat(ACT_MEM, '0, 1'b1);
    send_beat(ACT_FETCH, insn(OP_ADDI, 5'd7, 5'd0, 12'd1), 1'b0);
    send_beat(ACT_NONE, 32'hFFFF_FFFF, 1'b1);
    send_beat(ACT_START, '0, 1'b0);
    send_beat(ACT_MEM, 32'h1234_5678, 1'b0);
    send_beat(ACT_FETCH, insn(OP_LHU, 5'd7, 5'd3, 12'd2), 1'b0);
    send_beat(ACT_FETCH, insn(OP_ADD, 5'd8, 5'd3, 12'd0), 1'b0);
    send_beat(ACT_MEM, 32'hABCD_8765, 1'b0);
    send_beat(ACT_FETCH, insn(OP_JALR, 5'd8, 5'd3, 12'd1), 1'b0);
    // Unknown opcode halts, as does a fetch fault.
    send_beat(ACT_FETCH, 32'h0000_0023, 1'b0);
    send_beat(ACT_START, '0, 1'b0);
    send_beat(ACT_FETCH, insn(OP_ADDI, 5'd1, 5'd1, 12'd1), 1'b1);

    // Random phases, each with its own start_pc; one runs with no idling.
    write_start_pc(32'h0000_0000);
    random_phase(PhaseItems, 1'b0);
    write_start_pc(32'hFFFF_FFFF);
    random_phase(PhaseItems, 1'b1);
    write_start_pc($urandom);
    no_idle = 1'b1;
    random_phase(PhaseItems, 1'b0);
    no_idle = 1'b0;
    write_start_pc(StartPcReset);
    random_phase(PhaseItems, 1'b0);

    // Drain: every expected result back, then let the pipeline settle.
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    $display("covered %0d input beats and %0d checked results over five start_pc settings",
             beats_sent, checked);
    $display("%0d field mismatches in %0d cycles", err_cnt, cycles);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* risc_integer_instruction_executor.f */
hw/rtl/rie_pkg.sv
hw/rtl/rie_in_if.sv
hw/rtl/rie_out_if.sv
hw/rtl/rie_ram.sv
hw/rtl/rie_exec.sv
hw/rtl/risc_integer_instruction_executor.sv
tb/rie_scoreboard.sv
tb/risc_integer_instruction_executor_tb.sv
